// ----- src/tscu_pkg.sv -----
// ----------------------------------------------------------------------------
// tscu_pkg
// Shared constants, types and per-term divisor tables of the sine/cosine unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tscu_pkg;

  localparam int unsigned FRAC_BITS     = 28;
  localparam int unsigned OUT_FRAC_BITS = 14;
  localparam int unsigned NUM_TERMS     = 7;
  localparam int unsigned IDX_W         = 3;

  // Angles in unsigned Q.28; pi is the single-precision value of 3.1415927.
  localparam logic [31:0] PI_FIX      = 32'd843314880;
  localparam logic [31:0] HALF_PI_FIX = 32'd421657440;
  localparam logic [31:0] TWO_PI_FIX  = 32'd1686629760;

  localparam logic signed [31:0] ONE_FIX   = 32'sd268435456;
  localparam logic [63:0]        RND_Q28   = 64'd1 << (FRAC_BITS - 1);
  localparam logic [32:0]        RND_OUT   = 33'd1 << (FRAC_BITS - OUT_FRAC_BITS - 1);
  localparam logic [14:0]        OUT_ONE   = 15'd16384;

  // Data handed from one chain element to the next.
  typedef struct packed {
    logic               valid;
    logic               neg;
    logic [31:0]        sq;
    logic signed [31:0] term;
  } tscu_bus_t;

  // A divisor d is split as 2^shift * odd. magic is floor(2^32 / odd), held to
  // 2^32 - 1 for odd = 1, so a multiply and shift gives the quotient or one less.
  typedef struct packed {
    logic [6:0]  half;
    logic [1:0]  shift;
    logic [6:0]  odd;
    logic [31:0] magic;
  } tscu_div_t;

  function automatic tscu_div_t term_div(input logic [IDX_W-1:0] idx);
    tscu_div_t c;
    case (idx)
      3'd0: c = '{half: 7'd1,  shift: 2'd1, odd: 7'd1,  magic: 32'd4294967295};
      3'd1: c = '{half: 7'd6,  shift: 2'd2, odd: 7'd3,  magic: 32'd1431655765};
      3'd2: c = '{half: 7'd15, shift: 2'd1, odd: 7'd15, magic: 32'd286331153};
      3'd3: c = '{half: 7'd28, shift: 2'd3, odd: 7'd7,  magic: 32'd613566756};
      3'd4: c = '{half: 7'd45, shift: 2'd1, odd: 7'd45, magic: 32'd95443717};
      3'd5: c = '{half: 7'd66, shift: 2'd2, odd: 7'd33, magic: 32'd130150524};
      3'd6: c = '{half: 7'd91, shift: 2'd1, odd: 7'd91, magic: 32'd47197442};
      default: c = '{half: 7'd1, shift: 2'd1, odd: 7'd1, magic: 32'd4294967295};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/tscu_in_if.sv -----
// ----------------------------------------------------------------------------
// tscu_in_if
// Request channel: function select and angle in signed Q4.12.
// ----------------------------------------------------------------------------
`default_nettype none

interface tscu_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] angle;

  modport source (output valid, output req_type, output angle, input ready);
  modport sink   (input valid, input req_type, input angle, output ready);
endinterface

`default_nettype wire

// ----- src/tscu_out_if.sv -----
// ----------------------------------------------------------------------------
// tscu_out_if
// Result channel: sine or cosine in signed Q2.14.
// ----------------------------------------------------------------------------
`default_nettype none

interface tscu_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- src/tscu_front.sv -----
// ----------------------------------------------------------------------------
// tscu_front
// Range reduction of the angle to [0, pi) and squaring, five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tscu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic signed [15:0] angle_i,
  input  logic               ready_i,
  output tscu_pkg::tscu_bus_t bus_o
);

  logic [4:0] v_q;
  logic [4:0] en;

  logic [31:0] mag1_q, mag1_d;
  logic [30:0] mag2_q, mag2_d;
  logic [29:0] x3_q, x3_d;
  logic        neg3_q, neg3_d;
  logic [59:0] sqp_q, sqp_d;
  logic        neg4_q;
  logic [31:0] sq5_q, sq5_d;
  logic        neg5_q;

  logic signed [32:0] ang_ext;
  logic signed [32:0] shifted;
  logic [32:0]        flipped;
  logic [31:0]        red2;
  logic [31:0]        red3;
  logic [59:0]        sq_sum;

  // A stage loads when it is empty or its successor takes its item.
  always_comb begin
    en[4] = !v_q[4] || ready_i;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    ang_ext = {angle_i[15], angle_i, 16'h0000};
    shifted = ang_ext - (req_type_i ? $signed({1'b0, tscu_pkg::HALF_PI_FIX}) : 33'sd0);
    flipped = 33'd0 - shifted;
    mag1_d  = shifted[32] ? flipped[31:0] : shifted[31:0];
  end

  always_comb begin
    red2   = mag1_q - tscu_pkg::TWO_PI_FIX;
    mag2_d = (mag1_q >= tscu_pkg::TWO_PI_FIX) ? red2[30:0] : mag1_q[30:0];
  end

  // An angle of exactly pi takes the negated path.
  always_comb begin
    red3   = {1'b0, mag2_q} - tscu_pkg::PI_FIX;
    neg3_d = ({1'b0, mag2_q} >= tscu_pkg::PI_FIX);
    x3_d   = neg3_d ? red3[29:0] : mag2_q[29:0];
  end

  assign sqp_d  = 60'(x3_q) * 60'(x3_q);
  assign sq_sum = sqp_q + 60'(tscu_pkg::RND_Q28);
  assign sq5_d  = sq_sum[59:28];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < 5; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      mag1_q <= mag1_d;
    end
    if (en[1] && v_q[0]) begin
      mag2_q <= mag2_d;
    end
    if (en[2] && v_q[1]) begin
      x3_q   <= x3_d;
      neg3_q <= neg3_d;
    end
    if (en[3] && v_q[2]) begin
      sqp_q  <= sqp_d;
      neg4_q <= neg3_q;
    end
    if (en[4] && v_q[3]) begin
      sq5_q  <= sq5_d;
      neg5_q <= neg4_q;
    end
  end

  assign bus_o.valid = v_q[4];
  assign bus_o.neg   = neg5_q;
  assign bus_o.sq    = sq5_q;
  assign bus_o.term  = tscu_pkg::ONE_FIX;

endmodule

`default_nettype wire

// ----- src/tscu_cell.sv -----
// ----------------------------------------------------------------------------
// tscu_cell
// One factor of the nested series: t_out = 1 - round(s / d) * t_in, in five
// register stages (numerator, divide, correct, multiply, round).
// ----------------------------------------------------------------------------
`default_nettype none

module tscu_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tscu_pkg::IDX_W-1:0]     cell_idx_i,
  input  tscu_pkg::tscu_bus_t            bus_i,
  output logic                           ready_o,
  output tscu_pkg::tscu_bus_t            bus_o,
  input  logic                           ready_i
);

  tscu_pkg::tscu_div_t div;

  logic [4:0] v_q;
  logic [4:0] en;

  // Square and sign travel along with every stage.
  logic [31:0]        sq_q   [5];
  logic               neg_q  [5];
  logic signed [31:0] term_q [3];

  logic [31:0] num_a_q, num_a_d;
  logic [31:0] num_b_q;
  logic [31:0] quo0_q, quo0_d;
  logic [31:0] quo_q, quo_d;
  logic [63:0] prod_q, prod_d;
  logic        tneg_q;
  logic signed [31:0] term_e_q, term_e_d;

  logic [32:0] num_sum;
  logic [32:0] num_sh;
  logic [63:0] magic_prod;
  logic [38:0] back_prod;
  logic [31:0] rem;
  logic [31:0] tmag;
  logic [63:0] prod_rnd;
  logic [31:0] pmag;

  assign div = tscu_pkg::term_div(cell_idx_i);

  always_comb begin
    en[4] = !v_q[4] || ready_i;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];

  // Rounded quotient: floor((s + d/2) / 2^shift / odd).
  always_comb begin
    num_sum = {1'b0, bus_i.sq} + 33'(div.half);
    num_sh  = num_sum >> div.shift;
    num_a_d = num_sh[31:0];
  end

  // The reciprocal product is the quotient or one less.
  assign magic_prod = 64'(num_a_q) * 64'(div.magic);
  assign quo0_d     = magic_prod[63:32];

  always_comb begin
    back_prod = 39'(quo0_q) * 39'(div.odd);
    rem       = num_b_q - back_prod[31:0];
    quo_d     = quo0_q + 32'(rem >= 32'(div.odd));
  end

  always_comb begin
    tmag   = term_q[2][31] ? (32'd0 - term_q[2]) : term_q[2];
    prod_d = 64'(quo_q) * 64'(tmag);
  end

  // Round the magnitude half away from zero, then apply the sign of t.
  always_comb begin
    prod_rnd = prod_q + tscu_pkg::RND_Q28;
    pmag     = prod_rnd[59:28];
    term_e_d = tneg_q ? (tscu_pkg::ONE_FIX + $signed(pmag))
                      : (tscu_pkg::ONE_FIX - $signed(pmag));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= bus_i.valid;
      end
      for (int k = 1; k < 5; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && bus_i.valid) begin
      num_a_q   <= num_a_d;
      sq_q[0]   <= bus_i.sq;
      neg_q[0]  <= bus_i.neg;
      term_q[0] <= bus_i.term;
    end
    if (en[1] && v_q[0]) begin
      quo0_q    <= quo0_d;
      num_b_q   <= num_a_q;
      sq_q[1]   <= sq_q[0];
      neg_q[1]  <= neg_q[0];
      term_q[1] <= term_q[0];
    end
    if (en[2] && v_q[1]) begin
      quo_q     <= quo_d;
      sq_q[2]   <= sq_q[1];
      neg_q[2]  <= neg_q[1];
      term_q[2] <= term_q[1];
    end
    if (en[3] && v_q[2]) begin
      prod_q   <= prod_d;
      tneg_q   <= term_q[2][31];
      sq_q[3]  <= sq_q[2];
      neg_q[3] <= neg_q[2];
    end
    if (en[4] && v_q[3]) begin
      term_e_q <= term_e_d;
      sq_q[4]  <= sq_q[3];
      neg_q[4] <= neg_q[3];
    end
  end

  assign bus_o.valid = v_q[4];
  assign bus_o.neg   = neg_q[4];
  assign bus_o.sq    = sq_q[4];
  assign bus_o.term  = term_e_q;

endmodule

`default_nettype wire

// ----- src/tscu_back.sv -----
// ----------------------------------------------------------------------------
// tscu_back
// Output stage: applies the half-turn sign, rounds Q.28 to Q2.14 and
// saturates to plus or minus one, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tscu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tscu_pkg::tscu_bus_t bus_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  value_o
);

  logic               out_v_q;
  logic signed [15:0] value_q, value_d;
  logic               en;

  logic [31:0] tmag;
  logic [32:0] rnd;
  logic [18:0] mag;
  logic [14:0] sat;
  logic        sign;

  assign en      = !out_v_q || out_ready_i;
  assign ready_o = en;

  always_comb begin
    tmag    = bus_i.term[31] ? (32'd0 - bus_i.term) : bus_i.term;
    rnd     = {1'b0, tmag} + tscu_pkg::RND_OUT;
    mag     = rnd[32:14];
    sat     = (mag > 19'(tscu_pkg::OUT_ONE)) ? tscu_pkg::OUT_ONE : mag[14:0];
    sign    = bus_i.term[31] ^ bus_i.neg;
    value_d = sign ? $signed(16'd0 - {1'b0, sat}) : $signed({1'b0, sat});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= bus_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && bus_i.valid) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = value_q;

endmodule

`default_nettype wire

// ----- src/taylor_sine_cosine_unit.sv -----
// ----------------------------------------------------------------------------
// taylor_sine_cosine_unit
// Pipelined sine/cosine of a Q4.12 angle by a seven-factor nested Taylor
// product, result in Q2.14 saturated to plus or minus one.
//
//   channel | role   | payload
//   --------+--------+------------------------------------------------
//   in_i    | sink   | req_type (0 cosine, 1 sine), angle (s Q4.12)
//   out_o   | source | value (s Q2.14)
//
// One item per cycle sustained while the output is not stalled; five reduction
// and squaring stages, seven series cells of five stages each, one output stage.
// The chain of series cells sets the latency; each cell needs one reciprocal
// multiply, one correction and one series multiply with rounding.
// Reset clears only the valid bits. A stalled output holds the pipe; ready
// ripples back through the stages, so empty stages still fill while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_cosine_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tscu_in_if.sink    in_i,
  tscu_out_if.source out_o
);

  localparam logic [31:0] SQ_MAX = 32'd2650000000;

  tscu_pkg::tscu_bus_t bus [tscu_pkg::NUM_TERMS + 1];
  logic                rdy [tscu_pkg::NUM_TERMS + 1];

  tscu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .req_type_i (in_i.req_type),
    .angle_i    (in_i.angle),
    .ready_i    (rdy[0]),
    .bus_o      (bus[0])
  );

  // Cell k applies the factor with the (NUM_TERMS-1-k)-th divisor, innermost
  // factor first.
  for (genvar k = 0; k < tscu_pkg::NUM_TERMS; k++) begin : g_cell
    tscu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (tscu_pkg::IDX_W'(tscu_pkg::NUM_TERMS - 1 - k)),
      .bus_i      (bus[k]),
      .ready_o    (rdy[k]),
      .bus_o      (bus[k+1]),
      .ready_i    (rdy[k+1])
    );
  end

  tscu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bus_i       (bus[tscu_pkg::NUM_TERMS]),
    .ready_o     (rdy[tscu_pkg::NUM_TERMS]),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .value_o     (out_o.value)
  );

  // The input is refused only when every stage is full behind a stalled output.
  a_stall_only_from_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready)
  ) else $error("input refused without output back-pressure");

  // Range reduction keeps the angle below pi, which bounds its square.
  a_reduced_square: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    bus[0].valid |-> (bus[0].sq < SQ_MAX)
  ) else $error("squared angle beyond reduced range");

  a_value_saturated: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.value <= 16'sd16384 && out_o.value >= -16'sd16384)
  ) else $error("result outside plus or minus one");

endmodule

`default_nettype wire

// ----- tb/taylor_sine_cosine_unit_tb.sv -----
// ----------------------------------------------------------------------------
// taylor_sine_cosine_unit_tb
// Self-checking bench for the sine/cosine unit. A table of edge angles runs
// first. Random angles follow, weighted toward the pi/2, pi, 3*pi/2, 2*pi and
// 5*pi/2 boundaries. Results are checked against a typed table value or a
// bit-exact fixed-point evaluation of the nested Taylor product. Both channels
// idle in short random bursts, except in the last stretch of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_cosine_unit_tb;

  localparam logic REQ_COS = 1'b0;
  localparam logic REQ_SIN = 1'b1;

  localparam int N_DIRECTED   = 26;
  localparam int N_RANDOM     = 1525;
  localparam int N_CALM       = 300;
  localparam int WATCHDOG_MAX = 1000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic               req;
    logic signed [15:0] angle;
    logic               typed;
    logic signed [15:0] value;
  } angle_row_t;

  // The cosine of zero, and the sine of the first Q4.12 step past pi/2,
  // are exactly one.
  angle_row_t angle_rows [N_DIRECTED] = '{
    '{REQ_COS, 16'sd0,      1'b1, 16'sd16384},
    '{REQ_SIN, 16'sd6434,   1'b1, 16'sd16384},
    '{REQ_COS, 16'sd32767,  1'b0, 16'sd0},
    '{REQ_COS, -16'sd32768, 1'b0, 16'sd0},
    '{REQ_SIN, 16'sd32767,  1'b0, 16'sd0},
    '{REQ_SIN, -16'sd32768, 1'b0, 16'sd0},
    '{REQ_COS, 16'sd12867,  1'b0, 16'sd0},
    '{REQ_COS, 16'sd12868,  1'b0, 16'sd0},
    '{REQ_COS, -16'sd12867, 1'b0, 16'sd0},
    '{REQ_COS, -16'sd12868, 1'b0, 16'sd0},
    '{REQ_COS, 16'sd25735,  1'b0, 16'sd0},
    '{REQ_COS, 16'sd25736,  1'b0, 16'sd0},
    '{REQ_COS, -16'sd25736, 1'b0, 16'sd0},
    '{REQ_COS, 16'sd6433,   1'b0, 16'sd0},
    '{REQ_COS, 16'sd6434,   1'b0, 16'sd0},
    '{REQ_SIN, 16'sd6433,   1'b0, 16'sd0},
    '{REQ_SIN, 16'sd0,      1'b0, 16'sd0},
    '{REQ_SIN, -16'sd6434,  1'b0, 16'sd0},
    '{REQ_SIN, 16'sd19301,  1'b0, 16'sd0},
    '{REQ_SIN, 16'sd19302,  1'b0, 16'sd0},
    '{REQ_SIN, -16'sd19302, 1'b0, 16'sd0},
    '{REQ_SIN, 16'sd32169,  1'b0, 16'sd0},
    '{REQ_SIN, 16'sd32170,  1'b0, 16'sd0},
    '{REQ_COS, 16'sd1,      1'b0, 16'sd0},
    '{REQ_COS, -16'sd1,     1'b0, 16'sd0},
    '{REQ_SIN, 16'sd1,      1'b0, 16'sd0}
  };

  logic clk_i;
  logic rst_ni;

  tscu_in_if  in_if ();
  tscu_out_if out_if ();

  taylor_sine_cosine_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic signed [15:0] expected_values [$];
  int                 error_count = 0;
  int                 quiet_cycles = 0;
  bit                 bursts_on;
  int                 stall_left = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Magnitude rounded to nearest with ties away from zero, sign put back.
  function automatic longint round_away(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic signed [15:0] trig_value(input logic req,
                                                   input logic signed [15:0] angle);
    longint x;
    longint sq;
    longint term;
    longint d;
    longint q;
    longint r;
    bit     flip;
    x    = longint'(angle) * 65536;
    flip = 1'b0;
    if (req == REQ_SIN) x = x - longint'(tscu_pkg::HALF_PI_FIX);
    if (x < 0) x = -x;
    if (x >= longint'(tscu_pkg::TWO_PI_FIX)) x = x - longint'(tscu_pkg::TWO_PI_FIX);
    if (x >= longint'(tscu_pkg::PI_FIX)) begin
      x    = x - longint'(tscu_pkg::PI_FIX);
      flip = 1'b1;
    end
    sq   = round_away(x * x, tscu_pkg::FRAC_BITS);
    term = longint'(tscu_pkg::ONE_FIX);
    // Innermost factor first: divisors 182 down to 2.
    for (int i = tscu_pkg::NUM_TERMS - 1; i >= 0; i--) begin
      case (i)
        0:       d = 2;
        1:       d = 12;
        2:       d = 30;
        3:       d = 56;
        4:       d = 90;
        5:       d = 132;
        default: d = 182;
      endcase
      q    = (sq + d / 2) / d;
      term = longint'(tscu_pkg::ONE_FIX) - round_away(q * term, tscu_pkg::FRAC_BITS);
    end
    r = flip ? -term : term;
    r = round_away(r, tscu_pkg::FRAC_BITS - tscu_pkg::OUT_FRAC_BITS);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_angle(input logic req, input logic signed [15:0] angle,
                            input logic typed, input logic signed [15:0] value);
    int gap;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= req;
    in_if.angle    <= angle;
    do @(posedge clk_i); while (!in_if.ready);
    expected_values.push_back(typed ? value : trig_value(req, angle));
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] random_angle();
    int base;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0:       base = 6434;
          1:       base = 12868;
          2:       base = 19302;
          3:       base = 25736;
          default: base = 32170;
        endcase
        base = base + int'($urandom_range(0, 16)) - 8;
        return 16'(($urandom_range(0, 1) != 0) ? -base : base);
      end
      1:       return 16'(int'($urandom_range(0, 128)) - 64);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: ready drops in random bursts while bursts are enabled.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(1, 6) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    logic signed [15:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 out_if.value);
        error_count++;
      end else begin
        want = expected_values.pop_front();
        if (out_if.value !== want) begin
          $display("%0t: value mismatch, expected %0d, actual %0d", $time, want,
                   out_if.value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_MAX);
      $display("taylor_sine_cosine_unit_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid    = 1'b0;
    in_if.req_type = REQ_COS;
    in_if.angle    = '0;
    rst_ni         = 1'b0;
    bursts_on      = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (angle_rows[i]) begin
      send_angle(angle_rows[i].req, angle_rows[i].angle, angle_rows[i].typed,
                 angle_rows[i].value);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_CALM) bursts_on = 1'b0;
      send_angle(1'($urandom_range(0, 1)), random_angle(), 1'b0, 16'sd0);
    end
    in_if.valid <= 1'b0;

    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("taylor_sine_cosine_unit_tb passed");
    end else begin
      $display("taylor_sine_cosine_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
